// File: sv/su3_link_vector_accumulate_core_defines.svh
// assertion macros shared by the link vector accumulate rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef SU3_LINK_VECTOR_ACCUMULATE_CORE_DEFINES_SVH
`define SU3_LINK_VECTOR_ACCUMULATE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// antecedent in one cycle implies consequent in the same cycle
`define SVAC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next cycle
`define SVAC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SVAC_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SVAC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: sv/svac_pkg.sv
// shared types and constants for the link vector accumulate block
// no dependencies
package svac_pkg;

    // width of one real fixed point word on the ports
    localparam int DATA_W = 32;

    // full width of one exact 32x32 signed product
    localparam int PROD_W = 2 * DATA_W;

    // number of colour rows, one mac lane each
    localparam int NUM_ROWS = 3;

    // configuration register indexes (paddr[2])
    localparam logic REG_DAGGER = 1'b0;

    // pipeline control handed from the top level to every lane
    typedef struct packed {
        logic adv;    // whole pipeline moves this cycle
        logic v2;     // product sum stage holds an item
        logic last2;  // that item closes its site
    } svac_ctrl_t;

endpackage

// File: sv/svac_lane.sv
// one complex multiply accumulate lane: link row entry times vector component
// depends on svac_pkg
module svac_lane #(
    parameter int FRAC_BITS = 24,
    parameter int ACC_BITS  = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  svac_pkg::svac_ctrl_t              ctrl,
    input  logic signed [svac_pkg::DATA_W-1:0] link_re,
    input  logic signed [svac_pkg::DATA_W-1:0] link_im,
    input  logic signed [svac_pkg::DATA_W-1:0] vec_re,
    input  logic signed [svac_pkg::DATA_W-1:0] vec_im,
    output logic        [ACC_BITS-1:0]        fin_re,
    output logic        [ACC_BITS-1:0]        fin_im
);

    localparam int PW = svac_pkg::PROD_W;

    logic signed [PW-1:0] ac_reg, bd_reg, ad_reg, bc_reg;
    logic signed [PW-1:0] ac_next, bd_next, ad_next, bc_next;
    logic signed [PW-1:0] ac_sh, bd_sh, ad_sh, bc_sh;
    logic [ACC_BITS-1:0]  re_reg, im_reg, re_next, im_next;
    logic [ACC_BITS-1:0]  acc_re_reg, acc_im_reg;
    logic [ACC_BITS-1:0]  sum_re, sum_im;
    logic [ACC_BITS-1:0]  fin_re_reg, fin_im_reg;

    // four exact partial products
    always_comb begin
        ac_next = PW'(link_re) * PW'(vec_re);
        bd_next = PW'(link_im) * PW'(vec_im);
        ad_next = PW'(link_re) * PW'(vec_im);
        bc_next = PW'(link_im) * PW'(vec_re);
    end

    // arithmetic shift gives floor rounding, then complex combine mod 2^ACC_BITS
    always_comb begin
        ac_sh   = ac_reg >>> FRAC_BITS;
        bd_sh   = bd_reg >>> FRAC_BITS;
        ad_sh   = ad_reg >>> FRAC_BITS;
        bc_sh   = bc_reg >>> FRAC_BITS;
        re_next = ac_sh[ACC_BITS-1:0] - bd_sh[ACC_BITS-1:0];
        im_next = ad_sh[ACC_BITS-1:0] + bc_sh[ACC_BITS-1:0];
        sum_re  = acc_re_reg + re_reg;
        sum_im  = acc_im_reg + im_reg;
    end

    // product and combine stages
    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            ac_reg <= ac_next;
            bd_reg <= bd_next;
            ad_reg <= ad_next;
            bc_reg <= bc_next;
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

    // accumulators, cleared when a site closes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (ctrl.adv && ctrl.v2) begin
            acc_re_reg <= ctrl.last2 ? '0 : sum_re;
            acc_im_reg <= ctrl.last2 ? '0 : sum_im;
        end
    end

    // final site sums captured for the emit stage
    always_ff @(posedge aclk) begin
        if (ctrl.adv && ctrl.v2 && ctrl.last2) begin
            fin_re_reg <= sum_re;
            fin_im_reg <= sum_im;
        end
    end

    assign fin_re = fin_re_reg;
    assign fin_im = fin_im_reg;

endmodule

// File: sv/svac_emit.sv
// merge stage: negate and saturate the lane sums, hold them in the output register
// depends on svac_pkg
module svac_emit #(
    parameter int ACC_BITS = 48
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [ACC_BITS-1:0]                     fin_re [svac_pkg::NUM_ROWS],
    input  logic [ACC_BITS-1:0]                     fin_im [svac_pkg::NUM_ROWS],
    input  logic                                    fin_valid,
    input  logic                                    dagger,
    output logic                                    adv,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [2*svac_pkg::NUM_ROWS*svac_pkg::DATA_W-1:0] m_tdata
);

    localparam int DW    = svac_pkg::DATA_W;
    localparam int OUT_W = 2 * svac_pkg::NUM_ROWS * DW;
    localparam logic signed [ACC_BITS:0] SAT_MAX =
        {{(ACC_BITS + 2 - DW){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [ACC_BITS:0] SAT_MIN =
        {{(ACC_BITS + 2 - DW){1'b1}}, {(DW - 1){1'b0}}};

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             out_free, fin_move;

    // optional negation then clamp to the 32-bit range
    function automatic logic [DW-1:0] sat_neg(input logic [ACC_BITS-1:0] v,
                                              input logic neg);
        logic signed [ACC_BITS:0] w;
        logic        [DW-1:0]     r;
        w = $signed({v[ACC_BITS-1], v});
        if (neg) begin
            w = -w;
        end
        if (w > SAT_MAX) begin
            r = SAT_MAX[DW-1:0];
        end else if (w < SAT_MIN) begin
            r = SAT_MIN[DW-1:0];
        end else begin
            r = w[DW-1:0];
        end
        return r;
    endfunction

    // pack the three colour sums, sum0_re lowest
    always_comb begin
        out_data_next = '0;
        for (int r = 0; r < svac_pkg::NUM_ROWS; r++) begin
            out_data_next[(2 * r) * DW +: DW]     = sat_neg(fin_re[r], dagger);
            out_data_next[(2 * r + 1) * DW +: DW] = sat_neg(fin_im[r], dagger);
        end
    end

    // the pipeline stalls only when both the final sums and the output are held
    always_comb begin
        out_free = !out_valid_reg || m_tready;
        fin_move = fin_valid && out_free;
        adv      = !fin_valid || out_free;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fin_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_move) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: sv/su3_link_vector_accumulate_core.sv
// top level of the su3 link times vector accumulator with apb config port
// depends on svac_pkg, svac_lane, svac_emit and su3_link_vector_accumulate_core_defines.svh
//
// One request per cycle is taken on the s_ side while s_tready is high; each
// carries one column of a 3x3 complex link matrix and one complex vector
// component. Three mac lanes, one per colour row, each form four exact 32x32
// products, floor them by FRAC_BITS and add into ACC_BITS-bit wrapping
// accumulators. A request with s_tlast set closes the site: its sums pass
// through the product, combine, accumulate and output registers to m_,
// negated when the dagger register is 1 and saturated to 32 bits, and the
// accumulators restart from zero. The input side takes one request every
// cycle except while one result waits in the output register and a second
// finished result waits behind it; only then is s_tready held low. dagger
// lies at byte address 0 and may be written only while the block is idle.
`include "su3_link_vector_accumulate_core_defines.svh"

module su3_link_vector_accumulate_core #(
    parameter int FRAC_BITS = 24,
    parameter int ACC_BITS  = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    // apb configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // link_row0_re, link_row0_im, link_row1_re, link_row1_im,
    // link_row2_re, link_row2_im, vec_re, vec_im (32 bits each, lowest first)
    input  logic [255:0] s_tdata,
    input  logic         s_tlast,   // last_term
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // sum0_re, sum0_im, sum1_re, sum1_im, sum2_re, sum2_im (32 bits each, lowest first)
    output logic [191:0] m_tdata
);

    localparam int DW = svac_pkg::DATA_W;
    localparam int NR = svac_pkg::NUM_ROWS;

    logic                 dagger_reg;
    logic                 cfg_wr;
    logic                 v1_reg, v2_reg, last1_reg, last2_reg, fin_valid_reg;
    logic                 adv;
    svac_pkg::svac_ctrl_t ctrl;
    logic [ACC_BITS-1:0]  fin_re [NR];
    logic [ACC_BITS-1:0]  fin_im [NR];

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dagger_reg <= 1'b0;
        end else if (cfg_wr && (paddr[2] == svac_pkg::REG_DAGGER)) begin
            dagger_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == svac_pkg::REG_DAGGER) begin
            prdata = {31'b0, dagger_reg};
        end
    end

    // pipeline valid and site-close tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            last1_reg     <= 1'b0;
            last2_reg     <= 1'b0;
            fin_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= s_tvalid;
            last1_reg     <= s_tlast;
            v2_reg        <= v1_reg;
            last2_reg     <= last1_reg;
            fin_valid_reg <= v2_reg && last2_reg;
        end
    end

    assign s_tready = adv;

    always_comb begin
        ctrl.adv   = adv;
        ctrl.v2    = v2_reg;
        ctrl.last2 = last2_reg;
    end

    // one mac lane per colour row
    for (genvar r = 0; r < NR; r++) begin : g_lane
        svac_lane #(
            .FRAC_BITS (FRAC_BITS),
            .ACC_BITS  (ACC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .link_re (s_tdata[(2 * r) * DW +: DW]),
            .link_im (s_tdata[(2 * r + 1) * DW +: DW]),
            .vec_re  (s_tdata[(2 * NR) * DW +: DW]),
            .vec_im  (s_tdata[(2 * NR + 1) * DW +: DW]),
            .fin_re  (fin_re[r]),
            .fin_im  (fin_im[r])
        );
    end

    // merge, saturate and output register
    svac_emit #(
        .ACC_BITS (ACC_BITS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_re    (fin_re),
        .fin_im    (fin_im),
        .fin_valid (fin_valid_reg),
        .dagger    (dagger_reg),
        .adv       (adv),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // checks
    `SVAC_ASSERT_IMPL(a_stall_only_when_full, aclk, aresetn,
        !s_tready, fin_valid_reg && m_tvalid && !m_tready)
    `SVAC_ASSERT_IMPL(a_result_from_fin, aclk, aresetn,
        $rose(m_tvalid), $past(fin_valid_reg))
    `SVAC_ASSERT_NEXT(a_close_reaches_fin, aclk, aresetn,
        adv && v2_reg && last2_reg, fin_valid_reg)
    `SVAC_ASSERT_IMPL(a_dagger_only_on_write, aclk, aresetn,
        $past(aresetn) && !$past(cfg_wr), $stable(dagger_reg))

endmodule

// File: sim/su3_site_sum_check.sv
// result checker for the su3 link times vector accumulator
// depends on svac_pkg; watches the apb port and both streams, counts mismatches
module su3_site_sum_check #(
    parameter int FRAC_BITS = 24,
    parameter int ACC_BITS  = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // link_row0_re, link_row0_im, link_row1_re, link_row1_im,
    // link_row2_re, link_row2_im, vec_re, vec_im (32 bits each, lowest first)
    input  logic [255:0] s_tdata,
    input  logic         s_tlast,   // last_term
    input  logic         m_tvalid,
    input  logic         m_tready,
    // sum0_re, sum0_im, sum1_re, sum1_im, sum2_re, sum2_im (32 bits each, lowest first)
    input  logic [191:0] m_tdata,
    output int           mismatches,
    output int           sums_waiting,
    output int           sites_done
);

    // predicted colour accumulators: re/im of rows 0..2
    logic signed [ACC_BITS-1:0] colour_acc [2*svac_pkg::NUM_ROWS];
    logic                       negate_sums;
    logic [191:0]               expected_sums [$];
    int                         errs  = 0;
    int                         sites = 0;

    // exact product floored by the fraction width
    function automatic logic signed [63:0] floor_prod(logic signed [31:0] x,
                                                      logic signed [31:0] y);
        logic signed [63:0] p;
        p = x * y;
        return p >>> FRAC_BITS;
    endfunction

    // add one link column times one vector component into the three rows
    task accumulate_column(input logic [255:0] col);
        logic signed [31:0] a, b, c, d;
        logic signed [63:0] re, im;
        c = col[192 +: 32];
        d = col[224 +: 32];
        for (int r = 0; r < svac_pkg::NUM_ROWS; r++) begin
            a  = col[64*r +: 32];
            b  = col[64*r+32 +: 32];
            re = floor_prod(a, c) - floor_prod(b, d);
            im = floor_prod(a, d) + floor_prod(b, c);
            colour_acc[2*r]   = colour_acc[2*r] + re[ACC_BITS-1:0];
            colour_acc[2*r+1] = colour_acc[2*r+1] + im[ACC_BITS-1:0];
        end
    endtask

    // emitted sums: optional negation, then saturation to 32 bits
    function automatic logic [191:0] site_sums(
            input logic signed [ACC_BITS-1:0] acc [2*svac_pkg::NUM_ROWS],
            input logic neg);
        logic [191:0]       packed_sums;
        logic signed [63:0] v;
        for (int i = 0; i < 2*svac_pkg::NUM_ROWS; i++) begin
            v = acc[i];
            if (neg)
                v = -v;
            if (v > 64'sh7FFFFFFF)
                packed_sums[32*i +: 32] = 32'h7FFFFFFF;
            else if (v < -64'sh80000000)
                packed_sums[32*i +: 32] = 32'h80000000;
            else
                packed_sums[32*i +: 32] = v[31:0];
        end
        return packed_sums;
    endfunction

    always @(posedge aclk) begin
        logic [191:0] want;
        if (!aresetn) begin
            foreach (colour_acc[k])
                colour_acc[k] = '0;
            negate_sums = 1'b0;
            expected_sums.delete();
        end else begin
            // result side: compare against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    errs++;
                    $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                end else begin
                    want = expected_sums.pop_front();
                    for (int i = 0; i < 2*svac_pkg::NUM_ROWS; i++) begin
                        if (want[32*i +: 32] !== m_tdata[32*i +: 32]) begin
                            errs++;
                            $display("%0t: site %0d sum%0d_%s expected %0d actual %0d",
                                     $time, sites, i / 2, (i % 2) ? "im" : "re",
                                     $signed(want[32*i +: 32]),
                                     $signed(m_tdata[32*i +: 32]));
                        end
                    end
                    sites++;
                end
            end
            // register write
            if (psel && penable && pwrite && pready && paddr[2] == svac_pkg::REG_DAGGER)
                negate_sums = pwdata[0];
            // request side: accumulate, close the site on tlast
            if (s_tvalid && s_tready) begin
                accumulate_column(s_tdata);
                if (s_tlast) begin
                    expected_sums.push_back(site_sums(colour_acc, negate_sums));
                    foreach (colour_acc[k])
                        colour_acc[k] = '0;
                end
            end
        end
        mismatches   <= errs;
        sums_waiting <= expected_sums.size();
        sites_done   <= sites;
    end

endmodule

// File: sim/su3_link_vector_accumulate_core_tb.sv
// testbench top for su3_link_vector_accumulate_core: clock, reset, stimulus, verdict
// depends on svac_pkg, the core rtl and su3_site_sum_check
module su3_link_vector_accumulate_core_tb;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata  = '0;   // link rows 0..2 re/im, vec re/im, lowest first
    logic         s_tlast  = 1'b0; // last_term
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [191:0] m_tdata;         // sum0..2 re/im, lowest first

    int mismatches;
    int sums_waiting;
    int sites_done;
    int columns_sent = 0;
    bit gap_on       = 1'b1;
    bit stall_on     = 1'b1;

    su3_link_vector_accumulate_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    su3_site_sum_check sum_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .sums_waiting (sums_waiting),
        .sites_done   (sites_done)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side backpressure in random bursts
    initial begin
        wait (aresetn);
        forever begin
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (stall_on) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // one column request, with an optional gap before it
    task send_column(input logic [255:0] col, input logic last);
        if (gap_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= col;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        columns_sent++;
    endtask

    // drain all outstanding sums, then let the pipeline empty
    task settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sums_waiting != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task write_dagger(input bit v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {svac_pkg::REG_DAGGER, 2'b00};
        pwdata  <= {31'b0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one fixed point word: full range, near unity, or an extreme
    function automatic logic [31:0] pick_word(input bit tame);
        int sel;
        int v;
        sel = tame ? 5 : $urandom_range(0, 9);
        if (sel < 5)
            return $urandom;
        if (sel < 8) begin
            v = $urandom_range(0, 67108863) - 33554432;
            return v;
        end
        case ($urandom_range(0, 4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'hFFFFFFFF;
            default: return 32'h01000000;
        endcase
    endfunction

    // random sites of assorted lengths until the item budget is used
    task random_sites(input int budget);
        int stop_at;
        int len;
        bit tame;
        logic [255:0] col;
        stop_at = columns_sent + budget;
        while (columns_sent < stop_at) begin
            case ($urandom_range(0, 3))
                0: len = 48;
                1: len = $urandom_range(1, 3);
                default: len = $urandom_range(1, 60);
            endcase
            tame = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < len; k++) begin
                for (int w = 0; w < 8; w++)
                    col[32*w +: 32] = pick_word(tame);
                send_column(col, k == len - 1);
            end
        end
    endtask

    // extremes, floor rounding of tiny negatives, short multi-column sites
    task directed_columns();
        send_column({8{32'h7FFFFFFF}}, 1'b1);
        send_column({8{32'h80000000}}, 1'b1);
        send_column({{2{32'h80000000}}, {6{32'h7FFFFFFF}}}, 1'b1);
        send_column({32'h80000000, 32'h7FFFFFFF, {3{32'h7FFFFFFF, 32'h80000000}}}, 1'b1);
        send_column('0, 1'b1);
        send_column({32'hFFFFFFFF, 32'h00000001, {6{32'hFFFFFFFF}}}, 1'b0);
        send_column({32'h00000000, 32'hFE800000, {6{32'h01000000}}}, 1'b0);
        send_column({32'h7FFFFFFF, 32'h7FFFFFFF, {6{32'h00000001}}}, 1'b1);
        send_column({$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom}, 1'b0);
        send_column({$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom}, 1'b0);
        send_column({$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom}, 1'b1);
        send_column({4{32'h55555555, 32'hAAAAAAAA}}, 1'b1);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, plain then adjoint
        write_dagger(1'b0);
        directed_columns();
        settle();
        write_dagger(1'b1);
        directed_columns();
        settle();

        // random phases alternating dagger; the last one runs without idling
        for (int p = 0; p < 4; p++) begin
            write_dagger(p % 2 == 0);
            if (p == 3) begin
                gap_on   = 1'b0;
                stall_on = 1'b0;
            end
            // a long site of most negative values wraps the imaginary accumulators to
            // the most negative value, whose negation must saturate
            if (p == 0)
                for (int k = 0; k < 256; k++)
                    send_column({8{32'h80000000}}, k == 255);
            random_sites(255);
            settle();
        end

        $display("sent %0d link columns forming %0d sites, dagger off and on,",
                 columns_sent, sites_done);
        $display("including extreme values, accumulator wrap and saturated negation");
        if (mismatches == 0 && sums_waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
